// ===== rtl/core/assert_macros.svh =====
// Assertion macros used by sorted_int_table.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising clock edge, disabled while reset is held.
`define SIT_ASSERT(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
		else $error("assertion failed");

// Condition that must never be seen on a rising clock edge outside reset.
`define SIT_NEVER(label, clk, rst_n, cond) \
	`SIT_ASSERT(label, clk, rst_n, !(cond))

`endif

// ===== rtl/core/sit_pkg.sv =====
// Package for the sorted table: sizes, payload types, command codes, controller states.
package sit_pkg;

	localparam int TABLE_DEPTH = 1024;
	localparam int DATA_W      = 32;
	localparam int IDX_W       = $clog2(TABLE_DEPTH);
	localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

	typedef logic [IDX_W-1:0] idx_t;
	typedef logic [CNT_W-1:0] cnt_t;

	// command codes
	localparam logic CMD_INSERT = 1'b0;
	localparam logic CMD_FIND   = 1'b1;

	typedef struct packed {
		logic                     cmd;
		logic signed [DATA_W-1:0] value;
	} req_t;

	typedef struct packed {
		cnt_t position;
		logic found;
		logic full_res;
		cnt_t fill_count;
	} rsp_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SEARCH,
		ST_DECIDE,
		ST_SHIFT,
		ST_DRAIN,
		ST_PLACE,
		ST_DONE
	} state_t;

	// Probe index (lo + hi - 1) / 2 of the search range [lo, hi); lo < hi.
	function automatic idx_t probe_idx(input cnt_t lo, input cnt_t hi);
		logic [CNT_W:0] sum;
		sum = {1'b0, lo} + {1'b0, hi} - {{CNT_W{1'b0}}, 1'b1};
		return sum[IDX_W:1];
	endfunction

endpackage

// ===== rtl/core/sit_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port, registered read data.
module sit_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// read port, registered read data
	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

// ===== rtl/core/sorted_int_table.sv =====
// Sorted table of signed 32-bit values: binary search over a RAM, insert by shifting entries up.
// A find runs the binary search (at most 11 probes for 1024 entries), then decides and responds.
// An insert then shifts every entry above the slot up by one, one entry per cycle, drains the
// last move and places the key; with no entry to move it only places the key, and into a full
// table it writes nothing. One item at a time: a new request waits until the response is loaded.
// Reset clears the fill count and control; the RAM holds no reset value and is not swept.
`include "assert_macros.svh"

module sorted_int_table
	import sit_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_stall,
	input  req_t req,
	output logic rsp_valid,
	input  logic rsp_stall,
	output rsp_t rsp
);

	state_t state_q, state_nxt;

	req_t  key_q;
	cnt_t  cnt_q;
	cnt_t  lo_q;
	cnt_t  hi_q;
	idx_t  mid_q;
	idx_t  ptr_q;
	logic  hit_q;
	logic  full_q;
	logic  sh_vld_s1;
	idx_t  sh_addr_s1;
	logic  rsp_valid_q;
	rsp_t  rsp_q;

	logic              ram_we;
	idx_t              ram_waddr;
	logic [DATA_W-1:0] ram_wdata;
	idx_t              ram_raddr;
	logic [DATA_W-1:0] ram_rdata;

	logic req_xfer;
	logic rsp_load;
	logic gt, lt, hit;
	cnt_t mid_ext, nlo, nhi;
	logic search_end;
	logic shift_last;

	sit_ram #(
		.WIDTH(DATA_W),
		.DEPTH(TABLE_DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	assign req_xfer = req_valid && !req_stall;
	assign rsp_load = (state_q == ST_DONE) && (!rsp_valid_q || !rsp_stall);

	// compare the probed entry against the key and narrow the range
	always_comb begin
		gt         = $signed(ram_rdata) > key_q.value;
		lt         = $signed(ram_rdata) < key_q.value;
		hit        = !gt && !lt;
		mid_ext    = cnt_t'(mid_q);
		nlo        = lt ? mid_ext + cnt_t'(1) : lo_q;
		nhi        = gt ? mid_ext : hi_q;
		search_end = hit || (nlo >= nhi);
		shift_last = (cnt_t'(ptr_q) == lo_q);
	end

	// next state
	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (req_valid) begin
					state_nxt = (cnt_q == '0) ? ST_DECIDE : ST_SEARCH;
				end
			end
			ST_SEARCH: begin
				if (search_end) begin
					state_nxt = ST_DECIDE;
				end
			end
			ST_DECIDE: begin
				if (key_q.cmd == CMD_FIND || cnt_q == cnt_t'(TABLE_DEPTH)) begin
					state_nxt = ST_DONE;
				end else if (lo_q == cnt_q) begin
					state_nxt = ST_PLACE;
				end else begin
					state_nxt = ST_SHIFT;
				end
			end
			ST_SHIFT: begin
				if (shift_last) begin
					state_nxt = ST_DRAIN;
				end
			end
			ST_DRAIN: state_nxt = ST_PLACE;
			ST_PLACE: state_nxt = ST_DONE;
			ST_DONE: begin
				if (rsp_load) begin
					state_nxt = ST_IDLE;
				end
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

	// RAM ports and handshake outputs
	always_comb begin
		req_stall = (state_q != ST_IDLE);
		ram_raddr = mid_q;
		unique case (state_q)
			ST_IDLE:   ram_raddr = probe_idx('0, cnt_q);
			ST_SEARCH: ram_raddr = probe_idx(nlo, nhi);
			ST_SHIFT:  ram_raddr = ptr_q;
			default:   ram_raddr = mid_q;
		endcase
		if (state_q == ST_PLACE) begin
			ram_we    = 1'b1;
			ram_waddr = lo_q[IDX_W-1:0];
			ram_wdata = key_q.value;
		end else begin
			ram_we    = sh_vld_s1;
			ram_waddr = sh_addr_s1 + idx_t'(1);
			ram_wdata = ram_rdata;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			rsp_valid_q <= 1'b0;
			sh_vld_s1   <= 1'b0;
		end else begin
			state_q   <= state_nxt;
			sh_vld_s1 <= (state_q == ST_SHIFT);
			if (state_q == ST_PLACE) begin
				cnt_q <= cnt_q + cnt_t'(1);
			end
			if (rsp_load) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// search and shift datapath
	always_ff @(posedge clk) begin
		sh_addr_s1 <= ptr_q;
		case (state_q)
			ST_IDLE: begin
				if (req_xfer) begin
					key_q <= req;
					lo_q  <= '0;
					hi_q  <= cnt_q;
					hit_q <= 1'b0;
					mid_q <= probe_idx('0, cnt_q);
				end
			end
			ST_SEARCH: begin
				hi_q  <= nhi;
				hit_q <= hit;
				mid_q <= probe_idx(nlo, nhi);
				if (hit) begin
					lo_q <= (key_q.cmd == CMD_FIND) ? mid_ext : mid_ext + cnt_t'(1);
				end else begin
					lo_q <= nlo;
				end
			end
			ST_DECIDE: begin
				full_q <= (key_q.cmd == CMD_INSERT) && (cnt_q == cnt_t'(TABLE_DEPTH));
				ptr_q  <= idx_t'(cnt_q - cnt_t'(1));
			end
			ST_SHIFT: begin
				ptr_q <= ptr_q - idx_t'(1);
			end
			default: begin
			end
		endcase
		if (rsp_load) begin
			rsp_q.position   <= lo_q;
			rsp_q.found      <= hit_q && (key_q.cmd == CMD_FIND);
			rsp_q.full_res   <= full_q;
			rsp_q.fill_count <= cnt_q;
		end
	end

	// checks
	`SIT_NEVER(a_cnt_range, clk, arst_n, cnt_q > cnt_t'(TABLE_DEPTH))
	`SIT_NEVER(a_write_full, clk, arst_n, ram_we && cnt_q == cnt_t'(TABLE_DEPTH))
	`SIT_ASSERT(a_search_range, clk, arst_n, (state_q == ST_SEARCH) |-> (lo_q < hi_q))
	`SIT_ASSERT(a_one_item, clk, arst_n, req_xfer |=> req_stall)

endmodule
